>>> rtl/wsdf_pkg.sv
// shared types, codes and constants of the websocket frame deframer
`timescale 1ns / 1ps
`default_nettype none
package wsdf_pkg;

  // default width of the payload byte counter
  localparam int unsigned CountWidthDef = 32;

  // config register reset values
  localparam logic        ReqMaskRst    = 1'b1;
  localparam logic [31:0] MaxPayloadRst = 32'd65536;

  // config port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgRequireMask = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload  = 2'd1;

  // depth of the queue between parser and output stage
  localparam int unsigned QueueDepth = 2;

  // frame opcodes
  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'hA;

  // protocol error codes
  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_RSV        = 4'd1,
    ERR_FRAG_CTRL  = 4'd2,
    ERR_CTRL_LONG  = 4'd3,
    ERR_TOO_LARGE  = 4'd4,
    ERR_UNMASKED   = 4'd5,
    ERR_STRAY_CONT = 4'd6,
    ERR_DATA_FRAG  = 4'd7,
    ERR_CLOSE_ONE  = 4'd8,
    ERR_BAD_OPCODE = 4'd9
  } err_code_e;

  // one classified result on its way to the output stage
  typedef struct packed {
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic       byte_valid;
    logic [3:0] opcode;
    logic       msg_end;
    logic       err_flag;
    err_code_e  err_code;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/wsdf_front.sv
// frame parser: header, extended length, mask key and error checks
`timescale 1ns / 1ps
`default_nettype none
module wsdf_front #(
  parameter int unsigned COUNT_WIDTH = wsdf_pkg::CountWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [wsdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wsdf_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                               res_valid_o,
  output wsdf_pkg::res_t                     res_o
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  localparam int unsigned CntW = COUNT_WIDTH;

  // config registers
  logic        req_mask_q;
  logic [31:0] max_pay_q;

  // parser state
  phase_e          phase_q, phase_d;
  logic [2:0]      fcnt_q, fcnt_d;
  logic            fin_q, fin_d;
  logic [3:0]      opc_q, opc_d;
  logic            masked_q, masked_d;
  logic [63:0]     len_q, len_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic [31:0]     key_q, key_d;
  logic [1:0]      midx_q, midx_d;
  logic            in_frag_q, in_frag_d;
  logic [3:0]      frag_op_q, frag_op_d;
  logic            err_q, err_d;

  // per-transaction scratch values
  logic        do_finish;
  logic        do_end;
  logic [63:0] fin_len;
  logic [6:0]  len7;
  logic [3:0]  cur_op;
  logic        too_large;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_mask_q <= wsdf_pkg::ReqMaskRst;
      max_pay_q  <= wsdf_pkg::MaxPayloadRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wsdf_pkg::CfgRequireMask: req_mask_q <= cfg_data_i[0];
        wsdf_pkg::CfgMaxPayload:  max_pay_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // parse one byte
  always_comb begin
    phase_d   = phase_q;
    fcnt_d    = fcnt_q;
    fin_d     = fin_q;
    opc_d     = opc_q;
    masked_d  = masked_q;
    len_d     = len_q;
    remain_d  = remain_q;
    key_d     = key_q;
    midx_d    = midx_q;
    in_frag_d = in_frag_q;
    frag_op_d = frag_op_q;
    err_d     = err_q;
    do_finish = 1'b0;
    do_end    = 1'b0;
    fin_len   = 64'd0;
    len7      = data_byte_i[6:0];
    cur_op    = (opc_q == wsdf_pkg::OpCont) ? frag_op_q : opc_q;
    too_large = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i && !err_q) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d = data_byte_i[7];
          opc_d = data_byte_i[3:0];
          if ((data_byte_i & 8'h70) != 8'h00) begin
            err_d = 1'b1;
            res_valid_o = 1'b1;
            res_o.err_flag = 1'b1;
            res_o.err_code = wsdf_pkg::ERR_RSV;
          end else if (data_byte_i[3] && !data_byte_i[7]) begin
            err_d = 1'b1;
            res_valid_o = 1'b1;
            res_o.err_flag = 1'b1;
            res_o.err_code = wsdf_pkg::ERR_FRAG_CTRL;
          end else begin
            phase_d = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked_d = data_byte_i[7];
          if (opc_q[3] && (len7 > 7'd125)) begin
            err_d = 1'b1;
            res_valid_o = 1'b1;
            res_o.err_flag = 1'b1;
            res_o.err_code = wsdf_pkg::ERR_CTRL_LONG;
          end else if (len7 >= 7'd126) begin
            phase_d = PH_EXTLEN;
            fcnt_d  = (len7 == 7'd126) ? 3'd1 : 3'd7;
            len_d   = 64'd0;
          end else begin
            do_finish = 1'b1;
            fin_len   = {57'd0, len7};
          end
        end
        PH_EXTLEN: begin
          len_d = {len_q[55:0], data_byte_i};
          if (fcnt_q == 3'd0) begin
            do_finish = 1'b1;
            fin_len   = {len_q[55:0], data_byte_i};
          end else begin
            fcnt_d = fcnt_q - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], data_byte_i};
          if (fcnt_q == 3'd0) begin
            do_end = 1'b1;
          end else begin
            fcnt_d = fcnt_q - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          midx_d   = midx_q + 2'd1;
          remain_d = remain_q - CntW'(1);
          res_valid_o      = 1'b1;
          res_o.raw_byte   = data_byte_i;
          res_o.byte_valid = 1'b1;
          res_o.opcode     = cur_op;
          case (midx_q)
            2'd0:    res_o.key_byte = key_q[31:24];
            2'd1:    res_o.key_byte = key_q[23:16];
            2'd2:    res_o.key_byte = key_q[15:8];
            default: res_o.key_byte = key_q[7:0];
          endcase
          if (remain_q == CntW'(1)) begin
            phase_d       = PH_HDR0;
            res_o.msg_end = fin_q;
            if ((opc_q == wsdf_pkg::OpCont) && fin_q) begin
              in_frag_d = 1'b0;
              frag_op_d = 4'd0;
            end
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      // length complete: run the frame checks in priority order
      if (do_finish) begin
        too_large = (fin_len > {32'd0, max_pay_q}) || ((fin_len >> CntW) != 64'd0);
        if (too_large) begin
          err_d = 1'b1;
          res_valid_o = 1'b1;
          res_o.err_flag = 1'b1;
          res_o.err_code = wsdf_pkg::ERR_TOO_LARGE;
        end else if (!masked_d && req_mask_q) begin
          err_d = 1'b1;
          res_valid_o = 1'b1;
          res_o.err_flag = 1'b1;
          res_o.err_code = wsdf_pkg::ERR_UNMASKED;
        end else if ((opc_q == wsdf_pkg::OpCont) && !in_frag_q) begin
          err_d = 1'b1;
          res_valid_o = 1'b1;
          res_o.err_flag = 1'b1;
          res_o.err_code = wsdf_pkg::ERR_STRAY_CONT;
        end else if (((opc_q == wsdf_pkg::OpText) || (opc_q == wsdf_pkg::OpBin)) && in_frag_q)
        begin
          err_d = 1'b1;
          res_valid_o = 1'b1;
          res_o.err_flag = 1'b1;
          res_o.err_code = wsdf_pkg::ERR_DATA_FRAG;
        end else if ((opc_q == wsdf_pkg::OpClose) && (fin_len == 64'd1)) begin
          err_d = 1'b1;
          res_valid_o = 1'b1;
          res_o.err_flag = 1'b1;
          res_o.err_code = wsdf_pkg::ERR_CLOSE_ONE;
        end else if (!(opc_q inside {wsdf_pkg::OpCont, wsdf_pkg::OpText, wsdf_pkg::OpBin,
                                     wsdf_pkg::OpClose, wsdf_pkg::OpPing, wsdf_pkg::OpPong}))
        begin
          err_d = 1'b1;
          res_valid_o = 1'b1;
          res_o.err_flag = 1'b1;
          res_o.err_code = wsdf_pkg::ERR_BAD_OPCODE;
        end else begin
          remain_d = fin_len[CntW-1:0];
          if (((opc_q == wsdf_pkg::OpText) || (opc_q == wsdf_pkg::OpBin)) && !fin_q) begin
            in_frag_d = 1'b1;
            frag_op_d = opc_q;
          end
          key_d = 32'd0;
          if (masked_d) begin
            phase_d = PH_MASK;
            fcnt_d  = 3'd3;
          end else begin
            do_end = 1'b1;
          end
        end
      end

      // header done: go to payload, or close out an empty frame
      if (do_end) begin
        if (remain_d == '0) begin
          phase_d = PH_HDR0;
          if (opc_q == wsdf_pkg::OpCont) begin
            if (fin_q) begin
              in_frag_d     = 1'b0;
              frag_op_d     = 4'd0;
              res_valid_o   = 1'b1;
              res_o.opcode  = frag_op_q;
              res_o.msg_end = 1'b1;
            end
          end else if ((opc_q == wsdf_pkg::OpText) || (opc_q == wsdf_pkg::OpBin)) begin
            if (fin_q) begin
              res_valid_o   = 1'b1;
              res_o.opcode  = opc_q;
              res_o.msg_end = 1'b1;
            end
          end else begin
            res_valid_o   = 1'b1;
            res_o.opcode  = opc_q;
            res_o.msg_end = 1'b1;
          end
        end else begin
          phase_d = PH_PAYLOAD;
          midx_d  = 2'd0;
        end
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      fcnt_q    <= 3'd0;
      fin_q     <= 1'b0;
      opc_q     <= 4'd0;
      masked_q  <= 1'b0;
      len_q     <= 64'd0;
      remain_q  <= '0;
      key_q     <= 32'd0;
      midx_q    <= 2'd0;
      in_frag_q <= 1'b0;
      frag_op_q <= 4'd0;
      err_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      fcnt_q    <= fcnt_d;
      fin_q     <= fin_d;
      opc_q     <= opc_d;
      masked_q  <= masked_d;
      len_q     <= len_d;
      remain_q  <= remain_d;
      key_q     <= key_d;
      midx_q    <= midx_d;
      in_frag_q <= in_frag_d;
      frag_op_q <= frag_op_d;
      err_q     <= err_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/wsdf_fifo.sv
// short queue of classified results between parser and output stage
`timescale 1ns / 1ps
`default_nettype none
module wsdf_fifo #(
  parameter int unsigned DEPTH = wsdf_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire wsdf_pkg::res_t wr_data_i,
  input  wire logic           rd_en_i,
  output wsdf_pkg::res_t      rd_data_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  wsdf_pkg::res_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/wsdf_back.sv
// output stage: unmasks payload bytes and holds the oldest result
`timescale 1ns / 1ps
`default_nettype none
module wsdf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire wsdf_pkg::res_t q_data_i,
  input  wire logic           q_empty_i,
  output logic                q_rd_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic [7:0]          payload_byte_o,
  output logic                byte_valid_o,
  output logic [3:0]          msg_opcode_o,
  output logic                message_end_o,
  output logic                error_flag_o,
  output logic [3:0]          error_code_o
);

  logic       out_vld_q;
  logic [7:0] pay_q;
  logic       bvld_q;
  logic [3:0] op_q;
  logic       end_q;
  logic       err_q;
  logic [3:0] code_q;
  logic       load;

  // refill when the output slot is free or being taken
  assign load    = (!out_vld_q || pop_i) && !q_empty_i;
  assign q_rd_o  = load;
  assign empty_o = !out_vld_q;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (pop_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output payload with unmasking
  always_ff @(posedge clk_i) begin
    if (load) begin
      pay_q  <= q_data_i.byte_valid ? (q_data_i.raw_byte ^ q_data_i.key_byte) : 8'd0;
      bvld_q <= q_data_i.byte_valid;
      op_q   <= q_data_i.opcode;
      end_q  <= q_data_i.msg_end;
      err_q  <= q_data_i.err_flag;
      code_q <= q_data_i.err_code;
    end
  end

  assign payload_byte_o = pay_q;
  assign byte_valid_o   = bvld_q;
  assign msg_opcode_o   = op_q;
  assign message_end_o  = end_q;
  assign error_flag_o   = err_q;
  assign error_code_o   = code_q;

endmodule
`default_nettype wire

>>> rtl/websocket_frame_deframer_unit.sv
// top level of the websocket frame deframer
//
//  channel   handshake        payload
//  input     push / full      data_byte_i
//  result    empty / pop      payload_byte_o byte_valid_o msg_opcode_o message_end_o
//                             error_flag_o error_code_o
//  config    cfg_we_i         cfg_idx_i cfg_data_i (0 require_mask, 1 max_payload)
//
//  One byte is taken every cycle while full is low; the parser settles each byte in the
//  cycle it is taken; its result is queued and moves to the output register once that is
//  free or being popped. The two-entry result queue and the output register set how far
//  the result side may lag before full rises. Reset clears parser, queue and output slot.
//  After a protocol error one error result is given and later bytes are dropped.
`timescale 1ns / 1ps
`default_nettype none
module websocket_frame_deframer_unit #(
  parameter int unsigned COUNT_WIDTH = wsdf_pkg::CountWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    data_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [7:0]                         payload_byte_o,
  output logic                               byte_valid_o,
  output logic [3:0]                         msg_opcode_o,
  output logic                               message_end_o,
  output logic                               error_flag_o,
  output logic [3:0]                         error_code_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wsdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wsdf_pkg::CfgDataW-1:0] cfg_data_i
);

  logic           accept;
  logic           res_valid;
  wsdf_pkg::res_t res;
  wsdf_pkg::res_t q_data;
  logic           q_empty;
  logic           q_rd;

  // input transaction
  assign accept = push && !full;

  // parser
  wsdf_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result queue
  wsdf_fifo #(
    .DEPTH (wsdf_pkg::QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .rd_en_i   (q_rd),
    .rd_data_o (q_data),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  // output stage
  wsdf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_data_i       (q_data),
    .q_empty_i      (q_empty),
    .q_rd_o         (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .payload_byte_o (payload_byte_o),
    .byte_valid_o   (byte_valid_o),
    .msg_opcode_o   (msg_opcode_o),
    .message_end_o  (message_end_o),
    .error_flag_o   (error_flag_o),
    .error_code_o   (error_code_o)
  );

endmodule
`default_nettype wire

>>> test/websocket_frame_deframer_unit_test.sv
// self-checking testbench for the websocket frame deframer unit
`timescale 1ns / 1ps
module websocket_frame_deframer_unit_test;

  // cycles with no transaction on either side before the run is abandoned
  localparam int unsigned IdleLimit   = 4000;
  // settling time after the last result, covers parser plus result queue
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TargetBytes = 1650;
  localparam int unsigned PhaseCount  = 5;

  // parser position within a frame
  typedef enum logic [2:0] {
    ST_HEAD0,
    ST_HEAD1,
    ST_EXT_LEN,
    ST_KEY,
    ST_BODY
  } parse_st_e;

  // length encodings of the second header byte
  typedef enum int unsigned {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  // one result as seen on the output ports
  typedef struct packed {
    logic [7:0]          pbyte;
    logic                valid;
    logic [3:0]          opcode;
    logic                msg_end;
    logic                err;
    wsdf_pkg::err_code_e code;
  } deframed_t;

  // mirror of the deframer: tracks frame state and holds the results still owed
  class ws_frame_mirror;
    logic        need_mask;
    logic [31:0] size_limit;
    parse_st_e   phase;
    logic [2:0]  field_left;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] len_acc;
    logic [63:0] bytes_left;
    logic [31:0] key;
    logic [1:0]  key_pos;
    logic        frag_open;
    logic [3:0]  frag_opcode;
    logic        halted;
    deframed_t   awaiting[$];
    int          mismatches;

    function new();
      need_mask   = wsdf_pkg::ReqMaskRst;
      size_limit  = wsdf_pkg::MaxPayloadRst;
      phase       = ST_HEAD0;
      field_left  = '0;
      fin         = 1'b0;
      opcode      = wsdf_pkg::OpCont;
      masked      = 1'b0;
      len_acc     = '0;
      bytes_left  = '0;
      key         = '0;
      key_pos     = '0;
      frag_open   = 1'b0;
      frag_opcode = wsdf_pkg::OpCont;
      halted      = 1'b0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [wsdf_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
      if (idx == wsdf_pkg::CfgRequireMask) need_mask = val[0];
      else if (idx == wsdf_pkg::CfgMaxPayload) size_limit = val;
    endfunction

    function void add_result(logic [7:0] b, logic v, logic [3:0] op, logic e, logic er,
                             wsdf_pkg::err_code_e c);
      deframed_t r;
      r.pbyte   = b;
      r.valid   = v;
      r.opcode  = op;
      r.msg_end = e;
      r.err     = er;
      r.code    = c;
      awaiting.insert(awaiting.size(), r);
    endfunction

    // protocol error: one error result, then nothing until reset
    function void raise_error(wsdf_pkg::err_code_e c);
      halted = 1'b1;
      add_result(8'h00, 1'b0, wsdf_pkg::OpCont, 1'b0, 1'b1, c);
    endfunction

    // empty frame only reports when it completes a message or is a control frame
    function void close_empty();
      if (opcode == wsdf_pkg::OpCont) begin
        if (fin) begin
          add_result(8'h00, 1'b0, frag_opcode, 1'b1, 1'b0, wsdf_pkg::ERR_NONE);
          frag_open   = 1'b0;
          frag_opcode = wsdf_pkg::OpCont;
        end
      end else if (opcode == wsdf_pkg::OpText || opcode == wsdf_pkg::OpBin) begin
        if (fin) add_result(8'h00, 1'b0, opcode, 1'b1, 1'b0, wsdf_pkg::ERR_NONE);
      end else begin
        add_result(8'h00, 1'b0, opcode, 1'b1, 1'b0, wsdf_pkg::ERR_NONE);
      end
    endfunction

    function void header_done();
      if (bytes_left == 0) begin
        phase = ST_HEAD0;
        close_empty();
      end else begin
        phase   = ST_BODY;
        key_pos = '0;
      end
    endfunction

    // length known: run the frame checks in priority order
    function void length_done(logic [63:0] len);
      logic [63:0] cnt_max;
      // a shift by the full width wraps to all ones
      cnt_max = (64'd1 << wsdf_pkg::CountWidthDef) - 64'd1;
      if (len > {32'd0, size_limit} || len > cnt_max)
        raise_error(wsdf_pkg::ERR_TOO_LARGE);
      else if (!masked && need_mask)
        raise_error(wsdf_pkg::ERR_UNMASKED);
      else if (opcode == wsdf_pkg::OpCont && !frag_open)
        raise_error(wsdf_pkg::ERR_STRAY_CONT);
      else if ((opcode == wsdf_pkg::OpText || opcode == wsdf_pkg::OpBin) && frag_open)
        raise_error(wsdf_pkg::ERR_DATA_FRAG);
      else if (opcode == wsdf_pkg::OpClose && len == 64'd1)
        raise_error(wsdf_pkg::ERR_CLOSE_ONE);
      else if (!(opcode inside {wsdf_pkg::OpCont, wsdf_pkg::OpText, wsdf_pkg::OpBin,
                                wsdf_pkg::OpClose, wsdf_pkg::OpPing, wsdf_pkg::OpPong}))
        raise_error(wsdf_pkg::ERR_BAD_OPCODE);
      else begin
        bytes_left = len;
        if ((opcode == wsdf_pkg::OpText || opcode == wsdf_pkg::OpBin) && !fin) begin
          frag_open   = 1'b1;
          frag_opcode = opcode;
        end
        key = '0;
        if (masked) begin
          phase      = ST_KEY;
          field_left = 3'd3;
        end else begin
          header_done();
        end
      end
    endfunction

    // note one accepted input byte
    function void take_byte(logic [7:0] b);
      logic [7:0] kb;
      logic [3:0] op;
      if (halted) return;
      case (phase)
        ST_HEAD1: begin
          masked = b[7];
          if (opcode >= wsdf_pkg::OpClose && b[6:0] > 7'd125)
            raise_error(wsdf_pkg::ERR_CTRL_LONG);
          else if (b[6:0] >= 7'd126) begin
            phase      = ST_EXT_LEN;
            field_left = (b[6:0] == 7'd126) ? 3'd1 : 3'd7;
            len_acc    = '0;
          end else begin
            length_done({57'd0, b[6:0]});
          end
        end
        ST_EXT_LEN: begin
          len_acc = {len_acc[55:0], b};
          if (field_left == 0) length_done(len_acc);
          else field_left--;
        end
        ST_KEY: begin
          key = {key[23:0], b};
          if (field_left == 0) header_done();
          else field_left--;
        end
        ST_BODY: begin
          kb = key[31 - 8 * key_pos -: 8];
          op = (opcode == wsdf_pkg::OpCont) ? frag_opcode : opcode;
          key_pos++;
          bytes_left--;
          if (bytes_left == 0) begin
            phase = ST_HEAD0;
            if (opcode == wsdf_pkg::OpCont && fin) begin
              frag_open   = 1'b0;
              frag_opcode = wsdf_pkg::OpCont;
            end
          end
          add_result(b ^ kb, 1'b1, op, (bytes_left == 0) && fin, 1'b0, wsdf_pkg::ERR_NONE);
        end
        default: begin
          fin    = b[7];
          opcode = b[3:0];
          if (b[6:4] != 3'b000) raise_error(wsdf_pkg::ERR_RSV);
          else if (opcode >= wsdf_pkg::OpClose && !fin) raise_error(wsdf_pkg::ERR_FRAG_CTRL);
          else phase = ST_HEAD1;
        end
      endcase
    endfunction

    function void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // compare one accepted result against the oldest one owed
    function void match_result(deframed_t got);
      deframed_t want;
      if (awaiting.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual byte %0h valid %b op %0h",
                 $time, got.pbyte, got.valid, got.opcode);
        $display("%0t:   end %b err %b code %0d", $time, got.msg_end, got.err, got.code);
        return;
      end
      want = awaiting.pop_front();
      check_field("payload_byte", want.pbyte, got.pbyte);
      check_field("byte_valid", want.valid, got.valid);
      check_field("msg_opcode", want.opcode, got.opcode);
      check_field("message_end", want.msg_end, got.msg_end);
      check_field("error_flag", want.err, got.err);
      check_field("error_code", want.code, got.code);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          push;
  logic                          full;
  logic [7:0]                    data_byte_i;
  logic                          empty;
  logic                          pop;
  logic [7:0]                    payload_byte_o;
  logic                          byte_valid_o;
  logic [3:0]                    msg_opcode_o;
  logic                          message_end_o;
  logic                          error_flag_o;
  logic [3:0]                    error_code_o;
  logic                          cfg_we_i;
  logic [wsdf_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [wsdf_pkg::CfgDataW-1:0] cfg_data_i;

  ws_frame_mirror mirror;
  int             sent_total;
  int             quiet_cycles;
  logic           tx_steady;

  logic        mask_plan  [0:PhaseCount-1] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [31:0] limit_plan [0:PhaseCount-1] =
    '{32'd65536, 32'd1024, 32'hFFFF_FFFF, 32'd48, 32'd1024};

  websocket_frame_deframer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .payload_byte_o (payload_byte_o),
    .byte_valid_o   (byte_valid_o),
    .msg_opcode_o   (msg_opcode_o),
    .message_end_o  (message_end_o),
    .error_flag_o   (error_flag_o),
    .error_code_o   (error_code_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls with stretches of constant pop
  initial begin : result_side
    int   stall_left;
    logic steady;
    stall_left = 0;
    steady     = 1'b0;
    pop        = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 299) == 0) steady = !steady;
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_cycles();
      end
    end
  end

  // result transaction check
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      mirror.match_result('{payload_byte_o, byte_valid_o, msg_opcode_o, message_end_o,
                            error_flag_o, wsdf_pkg::err_code_e'(error_code_o)});
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // one input transaction; entered and left just after a falling edge, push left high
  task automatic send_byte(logic [7:0] b);
    int pause;
    if (!tx_steady && $urandom_range(0, 3) == 0) begin
      pause = gap_cycles();
      push  = 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    data_byte_i = b;
    push        = 1'b1;
    do @(posedge clk_i); while (full);
    mirror.take_byte(b);
    sent_total++;
    @(negedge clk_i);
  endtask

  // stop sending and wait until every owed result is out and the block is quiet
  task automatic quiesce();
    push = 1'b0;
    while (mirror.awaiting.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [wsdf_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_idx_i  = idx;
    cfg_data_i = val;
    cfg_we_i   = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mirror.write_reg(idx, val);
  endtask

  task automatic send_header(logic fin, logic [3:0] op, logic masked, logic [63:0] len,
                             len_form_e form, logic [31:0] key_val);
    int i;
    send_byte({fin, 3'b000, op});
    case (form)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, 7'd126});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, 7'd127});
        for (i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked)
      for (i = 3; i >= 0; i--) send_byte(key_val[8 * i +: 8]);
  endtask

  task automatic send_body(logic [63:0] len);
    longint unsigned n;
    for (n = 0; n < len; n++) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [31:0] random_key();
    if ($urandom_range(0, 9) == 0) return 32'd0;
    return $urandom;
  endfunction

  // one well-formed frame that fits the current fragment state; only data frame lengths are capped at the size limit
  task automatic random_frame();
    logic        fin;
    logic        masked;
    logic [3:0]  op;
    logic [63:0] len;
    len_form_e   form;
    int          pick;
    int          r;
    if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
    masked = mirror.need_mask ? 1'b1 : 1'($urandom_range(0, 1));
    pick   = $urandom_range(0, 99);
    r      = $urandom_range(0, 99);
    if (pick < 25) begin
      // control frame, may fall inside a fragmented message
      op   = (pick < 8) ? wsdf_pkg::OpClose : (pick < 17) ? wsdf_pkg::OpPing : wsdf_pkg::OpPong;
      fin  = 1'b1;
      form = LEN_SHORT;
      if (r < 5) len = 64'd125;
      else if (r < 15) len = $urandom_range(9, 124);
      else len = $urandom_range(0, 8);
      if (op == wsdf_pkg::OpClose && len == 64'd1) len = 64'd2;
    end else begin
      if (mirror.frag_open) begin
        op  = wsdf_pkg::OpCont;
        fin = ($urandom_range(0, 2) == 0);
      end else begin
        op  = $urandom_range(0, 1) ? wsdf_pkg::OpText : wsdf_pkg::OpBin;
        fin = ($urandom_range(0, 2) != 0);
      end
      if (r < 10) len = 64'd0;
      else if (r < 80) len = $urandom_range(1, 16);
      else if (r < 92) len = $urandom_range(17, 125);
      else len = $urandom_range(126, 300);
      if (len > {32'd0, mirror.size_limit}) len = {32'd0, mirror.size_limit};
      r = $urandom_range(0, 99);
      if (len <= 64'd125) form = (r < 80) ? LEN_SHORT : (r < 90) ? LEN_EXT16 : LEN_EXT64;
      else form = (r < 70) ? LEN_EXT16 : LEN_EXT64;
    end
    send_header(fin, op, masked, len, form, random_key());
    send_body(len);
  endtask

  // ends the run with one protocol error of a random kind, then stray bytes
  task automatic error_tail();
    wsdf_pkg::err_code_e kind;
    logic [3:0]          op;
    logic [63:0]         len;
    int                  r;
    kind = wsdf_pkg::err_code_e'($urandom_range(wsdf_pkg::ERR_RSV, wsdf_pkg::ERR_BAD_OPCODE));
    case (kind)
      wsdf_pkg::ERR_RSV:
        send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                   4'($urandom_range(0, 15))});
      wsdf_pkg::ERR_FRAG_CTRL:
        send_byte({1'b0, 3'b000, 4'($urandom_range(8, 15))});
      wsdf_pkg::ERR_CTRL_LONG: begin
        send_byte({1'b1, 3'b000, 4'($urandom_range(8, 15))});
        send_byte({1'($urandom_range(0, 1)), 7'($urandom_range(126, 127))});
      end
      wsdf_pkg::ERR_TOO_LARGE: begin
        // either just over the limit or a 64-bit length with its top bit set
        if ($urandom_range(0, 1))
          len = {32'd0, mirror.size_limit} + 64'd1 + $urandom_range(0, 3);
        else len = {1'b1, 31'($urandom), 32'($urandom)};
        send_header(1'b1, wsdf_pkg::OpText, 1'b1, len, LEN_EXT64, random_key());
      end
      wsdf_pkg::ERR_UNMASKED: begin
        write_cfg(wsdf_pkg::CfgRequireMask, 32'd1);
        send_header(1'b1, wsdf_pkg::OpBin, 1'b0, $urandom_range(0, 20), LEN_SHORT, 32'd0);
      end
      wsdf_pkg::ERR_STRAY_CONT: begin
        if (mirror.frag_open)
          send_header(1'b1, wsdf_pkg::OpCont, 1'b1, 64'd0, LEN_SHORT, random_key());
        send_header(1'b1, wsdf_pkg::OpCont, 1'b1, $urandom_range(0, 20), LEN_SHORT,
                    random_key());
      end
      wsdf_pkg::ERR_DATA_FRAG: begin
        if (!mirror.frag_open) begin
          send_header(1'b0, wsdf_pkg::OpText, 1'b1, 64'd3, LEN_SHORT, random_key());
          send_body(64'd3);
        end
        send_header(1'($urandom_range(0, 1)), wsdf_pkg::OpBin, 1'b1, $urandom_range(0, 20),
                    LEN_SHORT, random_key());
      end
      wsdf_pkg::ERR_CLOSE_ONE:
        send_header(1'b1, wsdf_pkg::OpClose, 1'b1, 64'd1, LEN_SHORT, random_key());
      default: begin
        // reserved opcodes, both data and control ranges
        r  = $urandom_range(0, 9);
        op = (r < 5) ? 4'(3 + r) : 4'(6 + r);
        send_header(1'b1, op, 1'b1, $urandom_range(0, 125), LEN_SHORT, random_key());
      end
    endcase
    // the block ignores everything from here on
    repeat (20) send_byte(8'($urandom_range(0, 255)));
  endtask

  // stimulus and final verdict
  initial begin : stimulus
    int p;
    mirror       = new();
    sent_total   = 0;
    quiet_cycles = 0;
    tx_steady    = 1'b0;
    rst_ni       = 1'b0;
    push         = 1'b0;
    data_byte_i  = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: masked text with extreme bytes, empty ping, empty two-piece message
    send_header(1'b1, wsdf_pkg::OpText, 1'b1, 64'd2, LEN_SHORT, 32'h0000_A5A5);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_header(1'b1, wsdf_pkg::OpPing, 1'b1, 64'd0, LEN_SHORT, 32'hFFFF_FFFF);
    send_header(1'b0, wsdf_pkg::OpBin, 1'b1, 64'd0, LEN_SHORT, 32'h1234_5678);
    send_header(1'b1, wsdf_pkg::OpCont, 1'b1, 64'd0, LEN_SHORT, 32'h8000_0001);

    // random phases, settings changed only while the block is idle
    for (p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        quiesce();
        write_cfg(wsdf_pkg::CfgRequireMask, {31'($urandom), mask_plan[p]});
        write_cfg(wsdf_pkg::CfgMaxPayload, limit_plan[p]);
        // unused register indexes must be ignored
        if (p == 2) begin
          write_cfg(wsdf_pkg::CfgIdxW'(2), $urandom);
          write_cfg(wsdf_pkg::CfgIdxW'(3), $urandom);
        end
      end
      while (sent_total < (p + 1) * TargetBytes / PhaseCount) random_frame();
    end

    quiesce();
    error_tail();
    quiesce();

    if (mirror.mismatches == 0 && mirror.awaiting.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/wsdf_pkg.sv
rtl/wsdf_front.sv
rtl/wsdf_fifo.sv
rtl/wsdf_back.sv
rtl/websocket_frame_deframer_unit.sv
test/websocket_frame_deframer_unit_test.sv
